[src/assert_macros.svh]
// Assertion helpers used by the circumcenter top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TCC_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcc assertion failed");

// Next-cycle implication.
`define TCC_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcc assertion failed");

`endif

[src/tcc_pkg.sv]
`default_nettype none
package tcc_pkg;
  localparam int CW      = 32;
  localparam int AB_W    = CW + 1;
  localparam int N_W     = 2 * AB_W + 1;
  localparam int L_W     = 2 * AB_W + 1;
  localparam int LN_W    = 2 * N_W + 2;
  localparam int X_W     = N_W + AB_W + 1;
  localparam int NUM_W   = L_W + X_W + 1;
  localparam int REM_W   = NUM_W + 1;
  localparam int DEN_W   = LN_W + 1;
  localparam int Q_W     = 2 * CW - 2;
  localparam int CMP_W   = DEN_W + Q_W + 1;
  localparam int SUM_W   = 2 * CW;
  localparam int MUL_W   = 128;
  localparam int LIMB    = 32;
  localparam int NLIMB   = MUL_W / LIMB;
  localparam int PROD_W  = 2 * MUL_W + 1;
  localparam int MUL_LAT = 5;
  localparam int DIV_LAT = Q_W + 1;
  localparam int S_N     = MUL_LAT + 1;
  localparam int S_L     = 2 * S_N;
  localparam int S_NUM   = 3 * S_N;
  localparam int S_DIV   = S_NUM + 1;
  localparam int S_OUT   = S_DIV + DIV_LAT + 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_DEGEN = 2'd1;
  localparam status_t ST_SAT   = 2'd2;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic   neg;
    logic   degen;
    coord_t coord;
  } tag_t;
endpackage
`default_nettype wire

[src/tcc_if.sv]
`default_nettype none
interface tcc_in_if;
  import tcc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t a_x, a_y, a_z;
  coord_t b_x, b_y, b_z;
  coord_t c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;
  logic    valid;
  logic    ready;
  coord_t  center_x, center_y, center_z;
  status_t status;
  modport source (output valid, center_x, center_y, center_z, status, input ready);
  modport sink (input valid, center_x, center_y, center_z, status, output ready);
endinterface
`default_nettype wire

[src/tcc_mul.sv]
`default_nettype none
module tcc_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tcc_pkg::MUL_W-1:0]  a,
  input  logic signed [tcc_pkg::MUL_W-1:0]  b,
  output logic signed [tcc_pkg::PROD_W-1:0] p
);
  import tcc_pkg::*;

  logic [MUL_W-1:0]          am_r, bm_r;
  logic [3:0]                ng_r;
  logic [2*LIMB-1:0]         pp_r [NLIMB][NLIMB];
  logic [MUL_W+2*LIMB-1:0]   row_r [NLIMB];
  logic [MUL_W+2*LIMB-1:0]   row_nxt [NLIMB];
  logic [2*MUL_W-1:0]        mag_r, mag_nxt;
  logic signed [PROD_W-1:0]  p_r;

  // sum each row of limb products, then the rows
  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NLIMB; j++) begin
        row_nxt[i] = row_nxt[i] + ((MUL_W+2*LIMB)'(pp_r[i][j]) << (LIMB * j));
      end
    end
    mag_nxt = '0;
    for (int i = 0; i < NLIMB; i++) begin
      mag_nxt = mag_nxt + ((2*MUL_W)'(row_r[i]) << (LIMB * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
      bm_r <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
      ng_r <= {ng_r[2:0], a[MUL_W-1] ^ b[MUL_W-1]};
      for (int i = 0; i < NLIMB; i++) begin
        for (int j = 0; j < NLIMB; j++) begin
          pp_r[i][j] <= (2*LIMB)'(am_r[LIMB*i +: LIMB]) * (2*LIMB)'(bm_r[LIMB*j +: LIMB]);
        end
      end
      row_r <= row_nxt;
      mag_r <= mag_nxt;
      p_r   <= ng_r[3] ? -PROD_W'(mag_r) : PROD_W'(mag_r);
    end
  end

  assign p = p_r;
endmodule
`default_nettype wire

[src/tcc_div.sv]
`default_nettype none
module tcc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tcc_pkg::REM_W-1:0]   rem_in,
  input  logic [tcc_pkg::DEN_W-1:0]   den_in,
  input  tcc_pkg::tag_t               tag_in,
  output logic [tcc_pkg::Q_W-1:0]     q,
  output logic                        big,
  output tcc_pkg::tag_t               tag_out
);
  import tcc_pkg::*;

  logic [REM_W-1:0]   rem_r   [DIV_LAT];
  logic [REM_W-1:0]   rem_nxt [DIV_LAT];
  logic [Q_W-1:0]     q_r     [DIV_LAT];
  logic [Q_W-1:0]     q_nxt   [DIV_LAT];
  logic [DEN_W-1:0]   den_r   [DIV_LAT];
  tag_t               tag_r   [DIV_LAT];
  logic [DIV_LAT-1:0] big_r;
  logic               big_nxt;

  // first stage flags a quotient past the output range, then one bit per stage
  always_comb begin
    logic [CMP_W-1:0] sh;
    logic             ge;
    big_nxt    = CMP_W'(rem_in) >= (CMP_W'(den_in) << Q_W);
    rem_nxt[0] = rem_in;
    q_nxt[0]   = '0;
    for (int j = 1; j < DIV_LAT; j++) begin
      sh         = CMP_W'(den_r[j-1]) << (Q_W - j);
      ge         = CMP_W'(rem_r[j-1]) >= sh;
      rem_nxt[j] = ge ? REM_W'(CMP_W'(rem_r[j-1]) - sh) : rem_r[j-1];
      q_nxt[j]   = q_r[j-1] | (Q_W'(ge) << (Q_W - j));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r    <= rem_nxt;
      q_r      <= q_nxt;
      big_r    <= {big_r[DIV_LAT-2:0], big_nxt};
      den_r[0] <= den_in;
      tag_r[0] <= tag_in;
      for (int j = 1; j < DIV_LAT; j++) begin
        den_r[j] <= den_r[j-1];
        tag_r[j] <= tag_r[j-1];
      end
    end
  end

  assign q       = q_r[DIV_LAT-1];
  assign big     = big_r[DIV_LAT-1];
  assign tag_out = tag_r[DIV_LAT-1];
endmodule
`default_nettype wire

[src/triangle_circumcenter_3d.sv]
`default_nettype none
// Circumcenter of one 3D triangle in signed Q16.16, one triangle accepted per
// cycle, passing through an input register for the edge vectors, three
// six-stage multiplier groups (a five-stage multiplier plus a summing register:
// cross product and squared lengths, second cross products and |n|^2, the
// weighted numerators), a rounding-offset register, a 63-stage restoring
// divider (a range check, then one quotient bit per stage) and the saturating
// output register. Status 1 marks a collinear triangle (zero center), 2 a
// clamped center. When the output is not taken the whole pipeline holds;
// nothing is dropped or repeated.
module triangle_circumcenter_3d (
  input logic           clk,
  input logic           rst_n,
  tcc_in_if.sink        in_ch,
  tcc_out_if.source     out_ch
);
  import tcc_pkg::*;

  logic          adv;
  logic [S_OUT:0] v_r;
  coord_t        pa [3], pb [3], pc [3];

  logic signed [AB_W-1:0]   ab_r [3], ac_r [3];
  coord_t                   a_r [3];
  logic signed [AB_W-1:0]   abd_r [S_N][3], acd_r [S_N][3];
  coord_t                   ad_r [S_NUM][3];

  logic signed [PROD_W-1:0] p1a [3], p1b [3], p1c [3], p1d [3];
  logic signed [N_W-1:0]    n_r [3];
  logic [L_W-1:0]           lab_r, lac_r;
  logic [L_W-1:0]           labd_r [S_N], lacd_r [S_N];

  logic signed [PROD_W-1:0] p2n [3], p2a [3], p2b [3], p2c [3], p2d [3];
  logic [LN_W-1:0]          ln_r;
  logic [LN_W-1:0]          lnd_r [S_N];
  logic signed [X_W-1:0]    nab_r [3], nac_r [3];

  logic signed [PROD_W-1:0] p3a [3], p3b [3];
  logic signed [NUM_W-1:0]  num_r [3];

  logic [REM_W-1:0]         rem_r [3];
  logic [DEN_W-1:0]         den_r;
  tag_t                     tg_r [3];

  logic [Q_W-1:0]           dq [3];
  logic                     dbig [3];
  tag_t                     dtag [3];

  coord_t                   cen_r [3], cen_nxt [3];
  status_t                  stat_r, stat_nxt;

  assign adv         = !v_r[S_OUT] || out_ch.ready;
  assign in_ch.ready = adv;

  assign pa[0] = in_ch.a_x;  assign pa[1] = in_ch.a_y;  assign pa[2] = in_ch.a_z;
  assign pb[0] = in_ch.b_x;  assign pb[1] = in_ch.b_y;  assign pb[2] = in_ch.b_z;
  assign pc[0] = in_ch.c_x;  assign pc[1] = in_ch.c_y;  assign pc[2] = in_ch.c_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[S_OUT-1:0], in_ch.valid};
    end
  end

  generate
    for (genvar i = 0; i < 3; i++) begin : g_ax
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      tcc_mul u_m1a (.clk, .en(adv), .a(MUL_W'(ab_r[J])), .b(MUL_W'(ac_r[K])), .p(p1a[i]));
      tcc_mul u_m1b (.clk, .en(adv), .a(MUL_W'(ab_r[K])), .b(MUL_W'(ac_r[J])), .p(p1b[i]));
      tcc_mul u_m1c (.clk, .en(adv), .a(MUL_W'(ab_r[i])), .b(MUL_W'(ab_r[i])), .p(p1c[i]));
      tcc_mul u_m1d (.clk, .en(adv), .a(MUL_W'(ac_r[i])), .b(MUL_W'(ac_r[i])), .p(p1d[i]));

      tcc_mul u_m2n (.clk, .en(adv), .a(MUL_W'(n_r[i])), .b(MUL_W'(n_r[i])), .p(p2n[i]));
      tcc_mul u_m2a (.clk, .en(adv), .a(MUL_W'(n_r[J])),
                     .b(MUL_W'(abd_r[S_N-1][K])), .p(p2a[i]));
      tcc_mul u_m2b (.clk, .en(adv), .a(MUL_W'(n_r[K])),
                     .b(MUL_W'(abd_r[S_N-1][J])), .p(p2b[i]));
      tcc_mul u_m2c (.clk, .en(adv), .a(MUL_W'(n_r[J])),
                     .b(MUL_W'(acd_r[S_N-1][K])), .p(p2c[i]));
      tcc_mul u_m2d (.clk, .en(adv), .a(MUL_W'(n_r[K])),
                     .b(MUL_W'(acd_r[S_N-1][J])), .p(p2d[i]));

      tcc_mul u_m3a (.clk, .en(adv), .a(MUL_W'(lacd_r[S_N-1])), .b(MUL_W'(nab_r[i])),
                     .p(p3a[i]));
      tcc_mul u_m3b (.clk, .en(adv), .a(MUL_W'(labd_r[S_N-1])), .b(MUL_W'(nac_r[i])),
                     .p(p3b[i]));

      tcc_div u_div (.clk, .en(adv), .rem_in(rem_r[i]), .den_in(den_r), .tag_in(tg_r[i]),
                     .q(dq[i]), .big(dbig[i]), .tag_out(dtag[i]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ab_r[i] <= {pb[i][CW-1], pb[i]} - {pa[i][CW-1], pa[i]};
        ac_r[i] <= {pc[i][CW-1], pc[i]} - {pa[i][CW-1], pa[i]};
        a_r[i]  <= pa[i];
      end
      abd_r[0] <= ab_r;
      acd_r[0] <= ac_r;
      for (int k = 1; k < S_N; k++) begin
        abd_r[k] <= abd_r[k-1];
        acd_r[k] <= acd_r[k-1];
      end
      ad_r[0] <= a_r;
      for (int k = 1; k < S_NUM; k++) begin
        ad_r[k] <= ad_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        n_r[i] <= N_W'(p1a[i] - p1b[i]);
      end
      lab_r <= L_W'(p1c[0] + p1c[1] + p1c[2]);
      lac_r <= L_W'(p1d[0] + p1d[1] + p1d[2]);
      labd_r[0] <= lab_r;
      lacd_r[0] <= lac_r;
      for (int k = 1; k < S_N; k++) begin
        labd_r[k] <= labd_r[k-1];
        lacd_r[k] <= lacd_r[k-1];
      end

      ln_r <= LN_W'(p2n[0] + p2n[1] + p2n[2]);
      for (int i = 0; i < 3; i++) begin
        nab_r[i] <= X_W'(p2a[i] - p2b[i]);
        nac_r[i] <= X_W'(p2c[i] - p2d[i]);
      end
      lnd_r[0] <= ln_r;
      for (int k = 1; k < S_N; k++) begin
        lnd_r[k] <= lnd_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NUM_W'(p3a[i] - p3b[i]);
      end

      // |num| + |n|^2 as one add or subtract, rounding the quotient to nearest
      den_r <= {lnd_r[S_N-1], 1'b0};
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= num_r[i][NUM_W-1] ?
                    REM_W'(lnd_r[S_N-1]) - REM_W'(num_r[i]) :
                    REM_W'(lnd_r[S_N-1]) + REM_W'(num_r[i]);
        tg_r[i].neg   <= num_r[i][NUM_W-1];
        tg_r[i].degen <= lnd_r[S_N-1] == '0;
        tg_r[i].coord <= ad_r[S_NUM-1][i];
      end

      cen_r  <= cen_nxt;
      stat_r <= stat_nxt;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] sv;
    stat_nxt = ST_OK;
    for (int i = 0; i < 3; i++) begin
      qs = $signed({2'b00, dq[i]});
      sv = SUM_W'(dtag[i].coord) + (dtag[i].neg ? -qs : qs);
      if (dbig[i]) begin
        cen_nxt[i] = dtag[i].neg ? C_MIN : C_MAX;
        stat_nxt   = ST_SAT;
      end else if (sv < SUM_W'(C_MIN)) begin
        cen_nxt[i] = C_MIN;
        stat_nxt   = ST_SAT;
      end else if (sv > SUM_W'(C_MAX)) begin
        cen_nxt[i] = C_MAX;
        stat_nxt   = ST_SAT;
      end else begin
        cen_nxt[i] = sv[CW-1:0];
      end
    end
    // collinear corners override everything
    if (dtag[0].degen) begin
      for (int i = 0; i < 3; i++) begin
        cen_nxt[i] = '0;
      end
      stat_nxt = ST_DEGEN;
    end
  end

  assign out_ch.valid    = v_r[S_OUT];
  assign out_ch.center_x = cen_r[0];
  assign out_ch.center_y = cen_r[1];
  assign out_ch.center_z = cen_r[2];
  assign out_ch.status   = stat_r;

`include "assert_macros.svh"
  `TCC_AST_IMP(a_stall_holds_input, v_r[S_OUT] && !out_ch.ready, !in_ch.ready)
  `TCC_AST_NXT(a_accept_enters, in_ch.valid && in_ch.ready, v_r[0])
  `TCC_AST_IMP(a_degen_zero, out_ch.valid && out_ch.status == ST_DEGEN,
    out_ch.center_x == '0 && out_ch.center_y == '0 && out_ch.center_z == '0)
endmodule
`default_nettype wire

[tb/sv/tcc_scoreboard.sv]
module tcc_scoreboard
  import tcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcc_in_if    in_ch,
  tcc_out_if   out_ch,
  output int   errors,
  output int   pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    coord_t  cx;
    coord_t  cy;
    coord_t  cz;
    status_t st;
  } center_t;

  center_t centers_due[$];

  function automatic center_t circumcenter(input coord_t p[9]);
    wide_t   a[3], ab[3], ac[3], n[3], nab[3], nac[3];
    wide_t   ln, lab, lac, num, mag, q, v;
    logic    neg;
    coord_t  res[3];
    status_t st;
    int      j, k;
    center_t r;
    st = ST_OK;
    for (int i = 0; i < 3; i++) begin
      a[i]  = wide_t'(p[i]);
      ab[i] = wide_t'(p[3+i]) - a[i];
      ac[i] = wide_t'(p[6+i]) - a[i];
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      n[i] = ab[j] * ac[k] - ab[k] * ac[j];
    end
    ln  = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    if (ln == 0) begin
      r.cx = '0;
      r.cy = '0;
      r.cz = '0;
      r.st = ST_DEGEN;
      return r;
    end
    lab = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
    lac = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      nab[i] = n[j] * ab[k] - n[k] * ab[j];
      nac[i] = n[j] * ac[k] - n[k] * ac[j];
    end
    for (int i = 0; i < 3; i++) begin
      num = lac * nab[i] - lab * nac[i];
      neg = num < 0;
      mag = neg ? -num : num;
      // round half away from zero on the magnitude
      q = (mag + ln) / (2 * ln);
      if (q >= (wide_t'(1) <<< 62)) begin
        res[i] = neg ? C_MIN : C_MAX;
        st = ST_SAT;
      end else begin
        v = a[i] + (neg ? -q : q);
        if (v < wide_t'(C_MIN)) begin
          v = wide_t'(C_MIN);
          st = ST_SAT;
        end
        if (v > wide_t'(C_MAX)) begin
          v = wide_t'(C_MAX);
          st = ST_SAT;
        end
        res[i] = v[CW-1:0];
      end
    end
    r.cx = res[0];
    r.cy = res[1];
    r.cz = res[2];
    r.st = st;
    return r;
  endfunction

  always @(posedge clk) begin
    coord_t  p[9];
    center_t e;
    int      bad;
    bad = 0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p = '{in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
            in_ch.c_x, in_ch.c_y, in_ch.c_z};
      centers_due = {centers_due, circumcenter(p)};
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (centers_due.size() == 0) begin
        $error("result item with nothing expected");
        bad = bad + 1;
      end else begin
        e = centers_due.pop_front();
        if (out_ch.center_x !== e.cx) begin
          $error("center_x expected %0d actual %0d", e.cx, out_ch.center_x);
          bad = bad + 1;
        end
        if (out_ch.center_y !== e.cy) begin
          $error("center_y expected %0d actual %0d", e.cy, out_ch.center_y);
          bad = bad + 1;
        end
        if (out_ch.center_z !== e.cz) begin
          $error("center_z expected %0d actual %0d", e.cz, out_ch.center_z);
          bad = bad + 1;
        end
        if (out_ch.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_ch.status);
          bad = bad + 1;
        end
      end
    end
    errors  <= errors + bad;
    pending <= centers_due.size();
  end

endmodule

[tb/sv/triangle_circumcenter_3d_tb.sv]
module triangle_circumcenter_3d_tb;
  import tcc_pkg::*;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_pct;
  int   stall_pct;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();

  triangle_circumcenter_3d u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tcc_scoreboard u_scoreboard (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_triangle(input coord_t p[9]);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= p[0];
    in_ch.a_y <= p[1];
    in_ch.a_z <= p[2];
    in_ch.b_x <= p[3];
    in_ch.b_y <= p[4];
    in_ch.b_z <= p[5];
    in_ch.c_x <= p[6];
    in_ch.c_y <= p[7];
    in_ch.c_z <= p[8];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic coord_t offset(input int bits);
    coord_t r;
    r = coord_t'($urandom) >>> (31 - bits);
    return r;
  endfunction

  task automatic random_triangle();
    coord_t p[9];
    coord_t d[3];
    int     kind;
    int     m;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) p[i] = coord_t'($urandom);
    case (kind)
      0, 1: ;
      2, 3, 4, 5: begin
        // small triangle anywhere in range
        m = $urandom_range(30, 4);
        for (int i = 3; i < 9; i++) p[i] = p[i % 3] + offset(m);
      end
      6: begin
        // corners on one line
        m = $urandom_range(20, 2);
        for (int i = 0; i < 3; i++) d[i] = offset(m);
        m = $urandom_range(5) - 2;
        for (int i = 0; i < 3; i++) begin
          p[3+i] = p[i] + d[i];
          p[6+i] = p[i] + d[i] * m;
        end
      end
      7: begin
        // two coincident corners
        for (int i = 0; i < 3; i++) p[3+i] = p[i];
      end
      8: begin
        // thin triangle: center far away
        m = $urandom_range(28, 10);
        for (int i = 0; i < 3; i++) begin
          d[i] = offset(m);
          p[3+i] = p[i] + d[i];
          p[6+i] = p[i] - d[i] + coord_t'($urandom_range(3));
        end
      end
      default: begin
        m = $urandom_range(16, 1);
        for (int i = 0; i < 9; i++) p[i] = offset(m);
      end
    endcase
    send_triangle(p);
  endtask

  initial begin
    coord_t p[9];
    in_ch.valid  = 1'b0;
    in_ch.a_x    = '0;
    in_ch.a_y    = '0;
    in_ch.a_z    = '0;
    in_ch.b_x    = '0;
    in_ch.b_y    = '0;
    in_ch.b_z    = '0;
    in_ch.c_x    = '0;
    in_ch.c_y    = '0;
    in_ch.c_z    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    p = '{default: '0};
    send_triangle(p);
    p = '{default: C_MAX};
    send_triangle(p);
    p = '{default: C_MIN};
    send_triangle(p);
    p = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
    send_triangle(p);
    p = '{32'h10000, 32'h20000, 32'h30000, 32'h50000, 32'h20000, 32'h30000,
          32'h10000, 32'h60000, 32'h30000};
    send_triangle(p);
    p = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    send_triangle(p);
    p = '{C_MIN, C_MIN, C_MIN, 0, 0, 0, C_MAX, C_MAX, C_MAX};
    send_triangle(p);
    p = '{C_MAX, 0, 0, C_MIN, 0, 0, 0, C_MAX, 0};
    send_triangle(p);
    p = '{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX};
    send_triangle(p);
    p = '{0, 0, 0, C_MAX, 0, 0, C_MIN, 1, 0};
    send_triangle(p);
    p = '{C_MIN, C_MIN, C_MIN, C_MIN + 1, C_MIN, C_MIN, C_MIN, C_MIN + 1, C_MIN};
    send_triangle(p);
    p = '{C_MAX, C_MAX, C_MAX, C_MAX - 1, C_MAX, C_MAX, C_MAX, C_MAX - 1, C_MAX};
    send_triangle(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(p);
    p = '{-1, -1, -1, 32'hFFFF, 0, 0, 0, 0, 32'h7FFF_0000};
    send_triangle(p);
    p = '{5, 5, 5, 5, 5, 5, 9, 9, 9};
    send_triangle(p);
    for (int i = 0; i < 10; i++) random_triangle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int i = 0; i < 163; i++) random_triangle();
    end
    in_ch.valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    // let the count take in the last item before draining
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS triangle_circumcenter_3d");
    end else begin
      $display("FAIL triangle_circumcenter_3d");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL triangle_circumcenter_3d");
    $finish;
  end

endmodule
